// ===== sv/ctlp_pkg.sv =====
// ----------------------------------------------------------------------------
// ctlp_pkg
// Shared constants, types and helpers for the CAN text line parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ctlp_pkg;

    // line buffer and field limits
    localparam int LINE_CAPACITY  = 64;
    localparam int MAX_DATA_BYTES = 8;
    localparam int MAX_ID_DIGITS  = 8;

    // derived widths
    localparam int CHAR_CNT_W = $clog2(LINE_CAPACITY);
    localparam int DATA_CNT_W = 4;
    localparam int ID_CNT_W   = $clog2(MAX_ID_DIGITS + 1);
    localparam int ID_W       = 29;
    localparam int BYTE_W     = 8;
    localparam int NUM_BYTES  = 8;

    // line prefix, first character in the top byte
    localparam int PREFIX_LEN = 7;
    localparam logic [PREFIX_LEN*8-1:0] LINE_PREFIX = "CAN_RX ";

    // character codes
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // decoded hex digit
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    // ascii hex digit decode
    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= "0" && c <= "9") begin
            h.val = 4'(c - 8'h30);
        end else if (c >= "a" && c <= "f") begin
            h.val = 4'(c - 8'h57);
        end else if (c >= "A" && c <= "F") begin
            h.val = 4'(c - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

// ===== sv/can_text_line_parser_unit.sv =====
// ----------------------------------------------------------------------------
// can_text_line_parser_unit
// Parses "CAN_RX <id> <data>" text lines one character a word and emits
// one frame for each accepted line.
// ----------------------------------------------------------------------------
// frame out: a frame appears on the output in the cycle after its CR or LF word
// throughput: one character word per cycle; the parse state registers
//   update in the same cycle, the only stall comes from a held output frame
// reset: synchronous active-low i_rst_n clears the parse state and the
//   output valid; the data byte registers are not reset
`default_nettype none

module can_text_line_parser_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // character input
    input  wire logic        i_rx_valid,
    output logic             o_rx_stall,
    input  wire logic [7:0]  i_rx_char,
    // frame output
    output logic             o_frame_valid,
    input  wire logic        i_frame_stall,
    output logic [28:0]      o_frame_id,
    output logic [3:0]       o_data_length,
    output logic [7:0]       o_data_byte_0,
    output logic [7:0]       o_data_byte_1,
    output logic [7:0]       o_data_byte_2,
    output logic [7:0]       o_data_byte_3,
    output logic [7:0]       o_data_byte_4,
    output logic [7:0]       o_data_byte_5,
    output logic [7:0]       o_data_byte_6,
    output logic [7:0]       o_data_byte_7
);

    localparam int CW = ctlp_pkg::CHAR_CNT_W;
    localparam int DW = ctlp_pkg::DATA_CNT_W;
    localparam int IW = ctlp_pkg::ID_CNT_W;
    localparam int BW = ctlp_pkg::BYTE_W;
    localparam int NB = ctlp_pkg::NUM_BYTES;

    // parse phase codes
    localparam logic [2:0] PH_PREFIX  = 3'd0;
    localparam logic [2:0] PH_ID      = 3'd1;
    localparam logic [2:0] PH_DATA    = 3'd2;
    localparam logic [2:0] PH_STOPPED = 3'd3;
    localparam logic [2:0] PH_REJECT  = 3'd4;

    // parse state
    logic [CW-1:0]             r_char_cnt, n_char_cnt;
    logic [2:0]                r_phase, n_phase;
    logic [ctlp_pkg::ID_W-1:0] r_id, n_id;
    logic [IW-1:0]             r_id_cnt, n_id_cnt;
    logic [DW-1:0]             r_data_cnt, n_data_cnt;
    logic [3:0]                r_nibble, n_nibble;
    logic                      r_nib_pend, n_nib_pend;
    logic [BW-1:0]             r_store [NB];

    // output register
    logic                      r_out_valid;
    logic [ctlp_pkg::ID_W-1:0] r_out_id;
    logic [DW-1:0]             r_out_len;
    logic [BW-1:0]             r_out_byte [NB];

    logic          accept;
    logic          is_eol;
    logic          emit;
    logic          store_we;
    logic [BW-1:0] store_wdata;
    logic [7:0]    prefix_char;
    ctlp_pkg::t_hex hx;

    // input handshake: stall only while a held frame is not taken
    assign o_rx_stall = r_out_valid && i_frame_stall;
    assign accept     = i_rx_valid && !o_rx_stall;
    assign is_eol     = (i_rx_char == ctlp_pkg::CHAR_LF) || (i_rx_char == ctlp_pkg::CHAR_CR);
    assign hx         = ctlp_pkg::hex_decode(i_rx_char);

    // expected prefix character at the current position
    always_comb begin
        prefix_char = 8'h00;
        if (r_char_cnt < CW'(ctlp_pkg::PREFIX_LEN)) begin
            prefix_char = ctlp_pkg::LINE_PREFIX[
                (ctlp_pkg::PREFIX_LEN - 1 - int'(r_char_cnt)) * 8 +: 8];
        end
    end

    // per-character next state
    always_comb begin
        n_char_cnt  = r_char_cnt;
        n_phase     = r_phase;
        n_id        = r_id;
        n_id_cnt    = r_id_cnt;
        n_data_cnt  = r_data_cnt;
        n_nibble    = r_nibble;
        n_nib_pend  = r_nib_pend;
        emit        = 1'b0;
        store_we    = 1'b0;
        store_wdata = {r_nibble, hx.val};

        if (is_eol) begin
            if (r_char_cnt != '0) begin
                emit       = (r_phase == PH_DATA) || (r_phase == PH_STOPPED);
                n_char_cnt = '0;
                n_phase    = PH_PREFIX;
                n_id       = '0;
                n_id_cnt   = '0;
                n_data_cnt = '0;
                n_nibble   = '0;
                n_nib_pend = 1'b0;
            end
        end else if (r_char_cnt != CW'(ctlp_pkg::LINE_CAPACITY - 1)) begin
            n_char_cnt = r_char_cnt + 1'b1;
            case (r_phase)
                PH_PREFIX: begin
                    if (r_char_cnt >= CW'(ctlp_pkg::PREFIX_LEN) ||
                        i_rx_char != prefix_char) begin
                        n_phase = PH_REJECT;
                    end else if (r_char_cnt == CW'(ctlp_pkg::PREFIX_LEN - 1)) begin
                        n_phase = PH_ID;
                    end
                end
                PH_ID: begin
                    if (i_rx_char == ctlp_pkg::CHAR_SPACE) begin
                        n_phase = (r_id_cnt == '0) ? PH_REJECT : PH_DATA;
                    end else if (r_id_cnt >= IW'(ctlp_pkg::MAX_ID_DIGITS)) begin
                        n_phase = PH_REJECT;
                    end else if (!hx.ok) begin
                        n_phase = PH_REJECT;
                    end else begin
                        n_id     = {r_id[ctlp_pkg::ID_W-5:0], hx.val};
                        n_id_cnt = r_id_cnt + 1'b1;
                    end
                end
                PH_DATA: begin
                    if (!r_nib_pend) begin
                        if (!hx.ok) begin
                            n_phase = PH_STOPPED;
                        end else begin
                            n_nibble   = hx.val;
                            n_nib_pend = 1'b1;
                        end
                    end else begin
                        n_nib_pend = 1'b0;
                        if (!hx.ok || r_data_cnt >= DW'(ctlp_pkg::MAX_DATA_BYTES)) begin
                            n_phase = PH_STOPPED;
                        end else begin
                            store_we   = 1'b1;
                            n_data_cnt = r_data_cnt + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_cnt <= '0;
            r_phase    <= PH_PREFIX;
            r_id       <= '0;
            r_id_cnt   <= '0;
            r_data_cnt <= '0;
            r_nibble   <= '0;
            r_nib_pend <= 1'b0;
        end else if (accept) begin
            r_char_cnt <= n_char_cnt;
            r_phase    <= n_phase;
            r_id       <= n_id;
            r_id_cnt   <= n_id_cnt;
            r_data_cnt <= n_data_cnt;
            r_nibble   <= n_nibble;
            r_nib_pend <= n_nib_pend;
        end
    end

    // data byte store
    always_ff @(posedge i_clk) begin
        if (accept && store_we) begin
            r_store[r_data_cnt[2:0]] <= store_wdata;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_frame_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload, unused bytes forced to zero
    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out_id  <= r_id;
            r_out_len <= r_data_cnt;
            for (int k = 0; k < NB; k++) begin
                r_out_byte[k] <= (DW'(k) < r_data_cnt) ? r_store[k] : '0;
            end
        end
    end

    assign o_frame_valid = r_out_valid;
    assign o_frame_id    = r_out_id;
    assign o_data_length = r_out_len;
    assign o_data_byte_0 = r_out_byte[0];
    assign o_data_byte_1 = r_out_byte[1];
    assign o_data_byte_2 = r_out_byte[2];
    assign o_data_byte_3 = r_out_byte[3];
    assign o_data_byte_4 = r_out_byte[4];
    assign o_data_byte_5 = r_out_byte[5];
    assign o_data_byte_6 = r_out_byte[6];
    assign o_data_byte_7 = r_out_byte[7];

endmodule

`default_nettype wire

// ===== dv/tb_can_text_line_parser_unit.sv =====
// ----------------------------------------------------------------------------
// tb_can_text_line_parser_unit
// Feeds character words into the CAN text line parser and checks every frame
// it emits. A line predictor inside a small scoreboard tracks the parse of
// each line and queues the frame it should produce. Directed lines come first,
// then random lines: mostly well-formed, plus broken lines, noise and long
// lines. These run under several idle and stall mixes and one long output
// hold-off.
// ----------------------------------------------------------------------------

module tb_can_text_line_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // parse phases of the line predictor
    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_ID,
        PH_DATA,
        PH_STOPPED,
        PH_REJECT
    } t_parse_phase;

    // one emitted frame, data[k] is data byte k
    typedef struct packed {
        logic [ctlp_pkg::ID_W-1:0]                id;
        logic [ctlp_pkg::DATA_CNT_W-1:0]          len;
        logic [ctlp_pkg::NUM_BYTES-1:0][7:0]      data;
    } t_frame;

    localparam int MAX_REPORTS   = 10;
    localparam int QUIET_LIMIT   = 3000;
    localparam int HOLD_OFF      = 300;
    localparam int DRAIN_CYCLES  = 10;
    localparam int PHASE_CHARS   = 130;
    localparam int HOLD_LINES    = 15;

    // line predictor and frame checker
    class t_frame_ledger;
        t_parse_phase phase;
        int unsigned  kept;
        logic [31:0]  id_acc;
        int unsigned  id_digits;
        logic [7:0]   store [ctlp_pkg::NUM_BYTES];
        int unsigned  n_bytes;
        logic [3:0]   nibble;
        bit           nibble_held;
        t_frame       frames_due[$];
        int unsigned  errors;
        int unsigned  chars;
        int unsigned  lines;
        int unsigned  frames_expected;
        int unsigned  frames_checked;

        function new();
            errors = 0;
            chars = 0;
            lines = 0;
            frames_expected = 0;
            frames_checked = 0;
            clear_line();
        endfunction

        function void clear_line();
            phase = PH_PREFIX;
            kept = 0;
            id_acc = '0;
            id_digits = 0;
            n_bytes = 0;
            nibble = '0;
            nibble_held = 1'b0;
        endfunction

        // hex digit value, -1 for anything else
        static function int hex_of(input logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c) - int'("0");
            if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
            if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
            return -1;
        endfunction

        // advance the predicted parse by one accepted word
        function void take_char(input logic [7:0] c);
            int     v;
            t_frame f;
            chars++;
            // end of line
            if (c == ctlp_pkg::CHAR_LF || c == ctlp_pkg::CHAR_CR) begin
                if (kept == 0) return;
                lines++;
                if (phase == PH_DATA || phase == PH_STOPPED) begin
                    f.id  = id_acc[ctlp_pkg::ID_W-1:0];
                    f.len = n_bytes[ctlp_pkg::DATA_CNT_W-1:0];
                    for (int k = 0; k < ctlp_pkg::NUM_BYTES; k++) begin
                        f.data[k] = (k < n_bytes) ? store[k] : 8'h00;
                    end
                    frames_due.insert(frames_due.size(), f);
                    frames_expected++;
                end
                clear_line();
                return;
            end
            // characters past the line buffer are dropped
            if (kept >= ctlp_pkg::LINE_CAPACITY - 1) return;
            v = hex_of(c);
            case (phase)
                PH_PREFIX: begin
                    if (kept >= ctlp_pkg::PREFIX_LEN ||
                        c != ctlp_pkg::LINE_PREFIX[(ctlp_pkg::PREFIX_LEN - 1 - kept) * 8 +: 8])
                    begin
                        phase = PH_REJECT;
                    end else if (kept == ctlp_pkg::PREFIX_LEN - 1) begin
                        phase = PH_ID;
                    end
                end
                PH_ID: begin
                    if (c == ctlp_pkg::CHAR_SPACE) begin
                        phase = (id_digits == 0) ? PH_REJECT : PH_DATA;
                    end else if (id_digits >= ctlp_pkg::MAX_ID_DIGITS || v < 0) begin
                        phase = PH_REJECT;
                    end else begin
                        id_acc = {id_acc[27:0], 4'(v)};
                        id_digits++;
                    end
                end
                PH_DATA: begin
                    if (!nibble_held) begin
                        if (v < 0) begin
                            phase = PH_STOPPED;
                        end else begin
                            nibble = 4'(v);
                            nibble_held = 1'b1;
                        end
                    end else begin
                        nibble_held = 1'b0;
                        if (v < 0 || n_bytes >= ctlp_pkg::MAX_DATA_BYTES) begin
                            phase = PH_STOPPED;
                        end else begin
                            store[n_bytes] = {nibble, 4'(v)};
                            n_bytes++;
                        end
                    end
                end
                default: begin
                end
            endcase
            kept++;
        endfunction

        // compare one emitted frame with the oldest predicted one
        function void match_frame(input t_frame got);
            t_frame want;
            bit     bad;
            if (frames_due.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("unexpected frame: id=%h len=%0d data=%h",
                             got.id, got.len, got.data);
                end
                return;
            end
            want = frames_due.pop_front();
            frames_checked++;
            bad = (got.id !== want.id) || (got.len !== want.len);
            for (int k = 0; k < ctlp_pkg::NUM_BYTES; k++) begin
                if (got.data[k] !== want.data[k]) bad = 1'b1;
            end
            if (bad) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("frame mismatch: expected id=%h len=%0d data=%h",
                             want.id, want.len, want.data);
                    $display("                got      id=%h len=%0d data=%h",
                             got.id, got.len, got.data);
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_rx_valid = 1'b0;
    logic [7:0]  i_rx_char = 8'h00;
    logic        i_frame_stall = 1'b0;
    logic        o_rx_stall;
    logic        o_frame_valid;
    logic [28:0] o_frame_id;
    logic [3:0]  o_data_length;
    logic [7:0]  o_data_byte_0;
    logic [7:0]  o_data_byte_1;
    logic [7:0]  o_data_byte_2;
    logic [7:0]  o_data_byte_3;
    logic [7:0]  o_data_byte_4;
    logic [7:0]  o_data_byte_5;
    logic [7:0]  o_data_byte_6;
    logic [7:0]  o_data_byte_7;

    t_frame_ledger sb;
    logic [7:0]  line_buf[$];
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_request = 0;
    int          hold_left = 0;

    can_text_line_parser_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_valid    (i_rx_valid),
        .o_rx_stall    (o_rx_stall),
        .i_rx_char     (i_rx_char),
        .o_frame_valid (o_frame_valid),
        .i_frame_stall (i_frame_stall),
        .o_frame_id    (o_frame_id),
        .o_data_length (o_data_length),
        .o_data_byte_0 (o_data_byte_0),
        .o_data_byte_1 (o_data_byte_1),
        .o_data_byte_2 (o_data_byte_2),
        .o_data_byte_3 (o_data_byte_3),
        .o_data_byte_4 (o_data_byte_4),
        .o_data_byte_5 (o_data_byte_5),
        .o_data_byte_6 (o_data_byte_6),
        .o_data_byte_7 (o_data_byte_7)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // frame receiver: random stall, or a long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            i_frame_stall <= 1'b1;
            hold_left--;
        end else begin
            i_frame_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // frame monitor
    always @(posedge i_clk) begin
        t_frame got;
        if (i_rst_n && o_frame_valid && !i_frame_stall) begin
            got.id  = o_frame_id;
            got.len = o_data_length;
            got.data = {o_data_byte_7, o_data_byte_6, o_data_byte_5, o_data_byte_4,
                        o_data_byte_3, o_data_byte_2, o_data_byte_1, o_data_byte_0};
            sb.match_frame(got);
        end
    end

    // watchdog on cycles with no word moving on either side
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_rx_valid && !o_rx_stall) || (o_frame_valid && !i_frame_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("watchdog: no word accepted for %0d cycles", QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // send one character word, called and returning just after a falling edge
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            i_rx_char  <= 8'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_char  <= c;
        forever begin
            @(posedge i_clk);
            if (!o_rx_stall) break;
        end
        sb.take_char(c);
        @(negedge i_clk);
    endtask

    // append one character to the pending line
    function automatic void append_char(input logic [7:0] c);
        line_buf.insert(line_buf.size(), c);
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) append_char(s[i]);
    endfunction

    function automatic logic [7:0] rand_hex();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(0, 21)];
    endfunction

    task automatic send_line();
        while (line_buf.size() != 0) send_char(line_buf.pop_front());
    endtask

    // random line: well-formed, broken, noise or long
    task automatic send_random_line();
        int kind;
        int nid;
        int npairs;
        int idx;
        kind = $urandom_range(0, 99);
        if (kind >= 75 && kind < 85) begin
            repeat ($urandom_range(0, 70)) append_char(8'($urandom_range(0, 255)));
        end else begin
            add_text("CAN_RX ");
            nid = (kind >= 60 && kind < 75) ? $urandom_range(0, 9) : $urandom_range(1, 8);
            repeat (nid) append_char(rand_hex());
            append_char(ctlp_pkg::CHAR_SPACE);
            npairs = (kind >= 85) ? $urandom_range(20, 30) : $urandom_range(0, 10);
            repeat (2 * npairs) append_char(rand_hex());
            // odd trailing digit
            if ($urandom_range(0, 3) == 0) append_char(rand_hex());
            // junk that ends data collection
            if ($urandom_range(0, 5) == 0) begin
                append_char(8'($urandom_range(8'h21, 8'h7e)));
                append_char(rand_hex());
                append_char(rand_hex());
            end
            // broken line: one character replaced by any byte
            if (kind >= 60 && kind < 75) begin
                idx = $urandom_range(0, line_buf.size() - 1);
                line_buf[idx] = 8'($urandom_range(0, 255));
            end
        end
        case ($urandom_range(0, 3))
            0: append_char(ctlp_pkg::CHAR_LF);
            1: append_char(ctlp_pkg::CHAR_CR);
            2: begin
                append_char(ctlp_pkg::CHAR_CR);
                append_char(ctlp_pkg::CHAR_LF);
            end
            default: begin
                append_char(ctlp_pkg::CHAR_LF);
                append_char(ctlp_pkg::CHAR_LF);
            end
        endcase
        send_line();
    endtask

    // main sequence
    initial begin
        int idle_by_phase[4];
        int stall_by_phase[4];
        int target;
        idle_by_phase  = '{0, 47, 0, 23};
        stall_by_phase = '{0, 0, 47, 23};
        sb = new();

        // reset
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed lines
        add_text("CAN_RX 1FFFFFFF 0011223344556677\n");
        add_text("CAN_RX FFFFFFFF FFFFFFFFFFFFFFFF\r");
        add_text("CAN_RX 0 \n");
        add_text("CAN_RX 0\n");
        add_text("CAN_RX  12\n");
        add_text("CAN_RX 123456789 00\n");
        add_text("CAN_RX 12G4 00\n");
        add_text("CAN_TX 1 00\n");
        add_text("CAN_R\n");
        add_text("can_rx 1 00\n");
        add_text("CAN_RX aBc 12 34\n");
        add_text("CAN_RX 7 1Z34\n");
        add_text("CAN_RX 7 123\n");
        add_text("CAN_RX 7 00112233445566778899\n");
        add_text("CAN_RX 5 12");
        append_char(8'h00);
        add_text("34\r");
        add_text("\n\r\r\n");
        add_text("CAN_RX 3 AB");
        repeat (60) append_char("x");
        add_text("\nCAN_RX 1 \r\n");
        // line that reaches the buffer end exactly with data digits
        add_text("CAN_RX 1 ");
        repeat (27) add_text("Ab");
        add_text("\n");
        append_char(8'h80);
        append_char(8'hff);
        append_char(8'h7f);
        append_char(8'h00);
        add_text("\n");
        send_line();

        // random lines under each idle mix
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_by_phase[p];
            stall_pct     = stall_by_phase[p];
            target        = sb.chars + PHASE_CHARS;
            while (sb.chars < target) begin
                send_random_line();
            end
        end

        // long output hold-off while short frames keep coming
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = HOLD_OFF;
        repeat (HOLD_LINES) begin
            add_text("CAN_RX ");
            append_char(rand_hex());
            append_char(ctlp_pkg::CHAR_SPACE);
            append_char(rand_hex());
            append_char(rand_hex());
            append_char(ctlp_pkg::CHAR_LF);
            send_line();
        end
        i_rx_valid <= 1'b0;

        // drain
        while (sb.frames_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.errors += sb.frames_due.size();

        $display("covered %0d character words, %0d non-empty lines, %0d frames checked",
                 sb.chars, sb.lines, sb.frames_checked);
        $display("idle mixes: none, sender, receiver, both, then one long output hold-off");
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d frame errors", sb.errors);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
